// ----- hw/rtl/frc_pkg.sv -----
// frc_pkg: shared types and constants for the frame rotate/flip/crop engine
// used by frc_ctrl, frc_dp and the top level; depends on nothing

package frc_pkg;

  // frame memory geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

  // field widths
  localparam int DIM_W  = 9;
  localparam int PIX_W  = 8;
  localparam int IDX_W  = 3;
  localparam int CFG_DW = 9;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_W     = 3'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_H     = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_VALUE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_CROP_LEFT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_CROP_TOP    = 3'd5;
  localparam logic [IDX_W-1:0] REG_CROP_RIGHT  = 3'd6;
  localparam logic [IDX_W-1:0] REG_CROP_BOTTOM = 3'd7;

  typedef enum logic [2:0] {
    MODE_PASS,
    MODE_THRESH,
    MODE_NEG,
    MODE_ROT_L,
    MODE_ROT_R,
    MODE_VFLIP,
    MODE_MIRROR,
    MODE_CROP
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_CLAMP,
    STAT_CROP_BAD,
    STAT_PAST_END
  } status_t;

  typedef enum logic {
    OP_LOAD,
    OP_FETCH
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic fetch;
    logic emit;
  } dp_cmd_t;

endpackage

// ----- hw/rtl/frc_ram.sv -----
// frc_ram: generic single-write, single-read memory with registered read data
// no dependencies

module frc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/frc_ctrl.sv -----
// frc_ctrl: handshake controller and sequencer of the frame engine
// depends on frc_pkg

module frc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  output logic              out_valid,
  input  logic              out_ready,
  output frc_pkg::dp_cmd_t  cmd
);

  frc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            is_fetch;

  // an item enters out of reset when idle and the output register is free or draining
  assign in_ready = rst_n && (state_r == frc_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_fetch = (frc_pkg::op_t'(in_operation) == frc_pkg::OP_FETCH);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frc_pkg::S_IDLE: begin
        if (accept && is_fetch) begin
          state_nxt = frc_pkg::S_READ;
        end
      end
      frc_pkg::S_READ: begin
        state_nxt = frc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = frc_pkg::S_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.load  = 1'b0;
    cmd.fetch = 1'b0;
    cmd.emit  = 1'b0;
    unique case (state_r)
      frc_pkg::S_IDLE: begin
        cmd.load  = accept && !is_fetch;
        cmd.fetch = accept && is_fetch;
      end
      frc_pkg::S_READ: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd.emit = 1'b0;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    priority if (cmd.load || cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  // output register is free when the memory data comes back
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == frc_pkg::S_READ |-> !out_valid_r)
    else $error("output register busy during read");

  // a read cycle always produces an item
  a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == frc_pkg::S_READ |=> out_valid_r)
    else $error("read cycle did not produce an item");

  // a fetch blocks input for its read cycle
  a_fetch_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_fetch) |=> (state_r == frc_pkg::S_READ && !in_ready))
    else $error("fetch did not enter read cycle");
`endif

endmodule

// ----- hw/rtl/frc_dp.sv -----
// frc_dp: datapath of the frame engine: registers, load and readout counters,
// address generation, frame memory and pixel transform; depends on frc_pkg, frc_ram

module frc_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  frc_pkg::dp_cmd_t             cmd,
  input  logic [frc_pkg::PIX_W-1:0]    pixel_in,
  input  logic                         cfg_we,
  input  logic [frc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [frc_pkg::CFG_DW-1:0]   cfg_wdata,
  output logic [frc_pkg::PIX_W-1:0]    pixel_out,
  output logic                         last,
  output logic [1:0]                   status
);

  localparam int DW = frc_pkg::DIM_W;
  localparam int PW = frc_pkg::PIX_W;
  localparam int CW = frc_pkg::COL_W;
  localparam int RW = frc_pkg::ROW_W;
  localparam logic [DW-1:0] W_MAX = DW'(frc_pkg::MAX_WIDTH);
  localparam logic [DW-1:0] H_MAX = DW'(frc_pkg::MAX_HEIGHT);
  localparam logic [DW-1:0] ONE   = DW'(1);

  // configuration registers
  frc_pkg::mode_t mode_r;
  logic [DW-1:0]  fw_r, fh_r;
  logic [PW-1:0]  maxv_r;
  logic [PW-1:0]  crop_l_r, crop_t_r, crop_r_r, crop_b_r;

  // position state
  logic [RW-1:0]  load_row_r, load_row_nxt;
  logic [CW-1:0]  load_col_r, load_col_nxt;
  logic [RW-1:0]  out_row_r, out_row_nxt;
  logic [CW-1:0]  out_col_r, out_col_nxt;
  logic           done_r, done_nxt;

  // fetch results waiting for memory data
  logic           pend_zero_r;
  logic           pend_last_r;
  frc_pkg::status_t pend_status_r;
  logic           fetch_last;
  frc_pkg::status_t fetch_status;

  // output register
  logic [PW-1:0]  pixel_r;
  logic           last_r;
  frc_pkg::status_t status_r;

  logic [DW-1:0]  w, h, ow, oh;
  logic           crop_ok, past;
  logic [RW-1:0]  ld_row;
  logic [CW-1:0]  ld_col;
  logic [DW-1:0]  ld_col_inc, ld_row_inc, rd_col_inc, rd_row_inc;
  logic [DW-1:0]  src_row, src_col;
  logic           clamp;
  logic [PW-1:0]  load_px;
  logic [PW-1:0]  rdata, xf_px;

  // effective frame size, saturated to 1..max
  always_comb begin
    priority if (fw_r == '0) w = ONE;
    else if (fw_r > W_MAX)   w = W_MAX;
    else                     w = fw_r;
    priority if (fh_r == '0) h = ONE;
    else if (fh_r > H_MAX)   h = H_MAX;
    else                     h = fh_r;
  end

  // output frame size
  assign crop_ok = (crop_l_r <= crop_r_r) && ({1'b0, crop_r_r} < w) &&
                   (crop_t_r <= crop_b_r) && ({1'b0, crop_b_r} < h);

  always_comb begin
    ow = w;
    oh = h;
    unique case (mode_r)
      frc_pkg::MODE_ROT_L, frc_pkg::MODE_ROT_R: begin
        ow = h;
        oh = w;
      end
      frc_pkg::MODE_CROP: begin
        if (crop_ok) begin
          ow = {1'b0, crop_r_r} - {1'b0, crop_l_r} + ONE;
          oh = {1'b0, crop_b_r} - {1'b0, crop_t_r} + ONE;
        end
      end
      default: begin
        ow = w;
        oh = h;
      end
    endcase
  end

  // load position with wrap
  always_comb begin
    if ({1'b0, load_row_r} >= h || {1'b0, load_col_r} >= w) begin
      ld_row = '0;
      ld_col = '0;
    end else begin
      ld_row = load_row_r;
      ld_col = load_col_r;
    end
    ld_col_inc   = {1'b0, ld_col} + ONE;
    ld_row_inc   = {1'b0, ld_row} + ONE;
    load_col_nxt = ld_col_inc[CW-1:0];
    load_row_nxt = ld_row;
    if (ld_col_inc >= w) begin
      load_col_nxt = '0;
      load_row_nxt = (ld_row_inc >= h) ? '0 : ld_row_inc[RW-1:0];
    end
  end

  assign clamp   = pixel_in > maxv_r;
  assign load_px = clamp ? maxv_r : pixel_in;

  // readout position and status of a fetch
  assign past = done_r || ({1'b0, out_row_r} >= oh) || ({1'b0, out_col_r} >= ow);

  always_comb begin
    rd_col_inc   = {1'b0, out_col_r} + ONE;
    rd_row_inc   = {1'b0, out_row_r} + ONE;
    out_col_nxt  = rd_col_inc[CW-1:0];
    out_row_nxt  = out_row_r;
    done_nxt     = done_r;
    fetch_last   = 1'b0;
    fetch_status = (mode_r == frc_pkg::MODE_CROP && !crop_ok) ?
                   frc_pkg::STAT_CROP_BAD : frc_pkg::STAT_OK;
    if (past) begin
      out_col_nxt  = out_col_r;
      done_nxt     = 1'b1;
      fetch_status = frc_pkg::STAT_PAST_END;
    end else if (rd_col_inc >= ow) begin
      out_col_nxt = '0;
      if (rd_row_inc >= oh) begin
        out_row_nxt = '0;
        done_nxt    = 1'b1;
        fetch_last  = 1'b1;
      end else begin
        out_row_nxt = rd_row_inc[RW-1:0];
      end
    end
  end

  // source address of the current output pixel
  always_comb begin
    src_row = {1'b0, out_row_r};
    src_col = {1'b0, out_col_r};
    unique case (mode_r)
      frc_pkg::MODE_ROT_L: begin
        src_row = {1'b0, out_col_r};
        src_col = w - ONE - {1'b0, out_row_r};
      end
      frc_pkg::MODE_ROT_R: begin
        src_row = h - ONE - {1'b0, out_col_r};
        src_col = {1'b0, out_row_r};
      end
      frc_pkg::MODE_VFLIP: begin
        src_row = h - ONE - {1'b0, out_row_r};
      end
      frc_pkg::MODE_MIRROR: begin
        src_col = w - ONE - {1'b0, out_col_r};
      end
      frc_pkg::MODE_CROP: begin
        if (crop_ok) begin
          src_row = {1'b0, crop_t_r} + {1'b0, out_row_r};
          src_col = {1'b0, crop_l_r} + {1'b0, out_col_r};
        end
      end
      default: begin
        src_row = {1'b0, out_row_r};
        src_col = {1'b0, out_col_r};
      end
    endcase
  end

  // frame memory
  frc_ram #(
    .WIDTH (PW),
    .DEPTH (frc_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr ({ld_row, ld_col}),
    .wdata (load_px),
    .re    (cmd.fetch && !past),
    .raddr ({src_row[RW-1:0], src_col[CW-1:0]}),
    .rdata (rdata)
  );

  // gray level transform on the read data
  always_comb begin
    unique case (mode_r)
      frc_pkg::MODE_THRESH: xf_px = (rdata < (maxv_r >> 1)) ? '0 : maxv_r;
      frc_pkg::MODE_NEG:    xf_px = (rdata > maxv_r) ? '0 : maxv_r - rdata;
      default:              xf_px = rdata;
    endcase
  end

  // configuration writes, load and readout counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= frc_pkg::MODE_PASS;
      fw_r       <= W_MAX;
      fh_r       <= H_MAX;
      maxv_r     <= '1;
      crop_l_r   <= '0;
      crop_t_r   <= '0;
      crop_r_r   <= '1;
      crop_b_r   <= '1;
      load_row_r <= '0;
      load_col_r <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      done_r     <= 1'b0;
    end else begin
      priority if (cfg_we) begin
        unique case (cfg_index)
          frc_pkg::REG_MODE:        mode_r   <= frc_pkg::mode_t'(cfg_wdata[2:0]);
          frc_pkg::REG_FRAME_W: begin
            fw_r       <= cfg_wdata;
            load_row_r <= '0;
            load_col_r <= '0;
          end
          frc_pkg::REG_FRAME_H: begin
            fh_r       <= cfg_wdata;
            load_row_r <= '0;
            load_col_r <= '0;
          end
          frc_pkg::REG_MAX_VALUE:   maxv_r   <= cfg_wdata[PW-1:0];
          frc_pkg::REG_CROP_LEFT:   crop_l_r <= cfg_wdata[PW-1:0];
          frc_pkg::REG_CROP_TOP:    crop_t_r <= cfg_wdata[PW-1:0];
          frc_pkg::REG_CROP_RIGHT:  crop_r_r <= cfg_wdata[PW-1:0];
          frc_pkg::REG_CROP_BOTTOM: crop_b_r <= cfg_wdata[PW-1:0];
          default:                  mode_r   <= mode_r;
        endcase
        // any register write rewinds the readout
        out_row_r <= '0;
        out_col_r <= '0;
        done_r    <= 1'b0;
      end else if (cmd.load) begin
        load_row_r <= load_row_nxt;
        load_col_r <= load_col_nxt;
        out_row_r  <= '0;
        out_col_r  <= '0;
        done_r     <= 1'b0;
      end else if (cmd.fetch) begin
        out_row_r <= out_row_nxt;
        out_col_r <= out_col_nxt;
        done_r    <= done_nxt;
      end
    end
  end

  // fetch results held over the memory read
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      pend_zero_r   <= past;
      pend_last_r   <= fetch_last;
      pend_status_r <= fetch_status;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pixel_r  <= '0;
      last_r   <= 1'b0;
      status_r <= clamp ? frc_pkg::STAT_CLAMP : frc_pkg::STAT_OK;
    end else if (cmd.emit) begin
      pixel_r  <= pend_zero_r ? '0 : xf_px;
      last_r   <= pend_last_r;
      status_r <= pend_status_r;
    end
  end

  assign pixel_out = pixel_r;
  assign last      = last_r;
  assign status    = status_r;

endmodule

// ----- hw/rtl/frame_rotate_flip_crop.sv -----
// Loads go straight to the output register, one item per cycle while the output is taken.
// A fetch does address generation into the frame memory, then its registered read and
// transform into the output register, and holds off input until it is done.
// Reset (rst_n low, synchronous) clears the controller, counters and config registers to
// defaults; the frame memory is not cleared and holds garbage until each entry is loaded.
// frame_rotate_flip_crop: top level; depends on frc_pkg, frc_ctrl, frc_dp, frc_ram

module frame_rotate_flip_crop (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [frc_pkg::PIX_W-1:0]   in_pixel_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [frc_pkg::PIX_W-1:0]   out_pixel_out,
  output logic                        out_last,
  output logic [1:0]                  out_status,
  input  logic                        cfg_we,
  input  logic [frc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [frc_pkg::CFG_DW-1:0]  cfg_wdata
);

  frc_pkg::dp_cmd_t cmd;

  // sequencer and handshake
  frc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  // datapath with frame memory
  frc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .pixel_in  (in_pixel_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pixel_out (out_pixel_out),
    .last      (out_last),
    .status    (out_status)
  );

endmodule
